### sv/msso_pkg.sv
// shared widths, register codes, limits and the quarter-wave sine table
package msso_pkg;

  localparam int ELAPSED_W   = 20;
  localparam int BPM_W       = 8;
  localparam int MUL_W       = 11;
  localparam int AMP_W       = 8;
  localparam int OFFSET_W    = 16;
  localparam int CHANNEL_W   = 2;
  localparam int PULSE_W     = 12;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  localparam int NUM_CHANNELS_DEF = 3;
  localparam int PHASE_BITS_DEF   = 32;
  localparam int NUM_OFFSETS      = 3;

  localparam int BPM_MIN = 40;
  localparam int BPM_MAX = 200;
  localparam int MUL_MIN = 26;
  localparam int MUL_MAX = 1280;

  localparam int BPM_RST  = 90;
  localparam int MUL_RST  = 64;
  localparam int AMP_RST  = 90;
  localparam int OFF0_RST = 0;
  localparam int OFF1_RST = 8192;
  localparam int OFF2_RST = 16384;

  localparam int RATE_W = BPM_W + MUL_W;
  localparam int PROD_W = ELAPSED_W + RATE_W;

  // 60e6 us per minute times 256 for the q8 multiplier
  localparam logic [63:0] TURN_DEN = 64'd15360000000;
  localparam int REM_W = $clog2(TURN_DEN);

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam int SINE_ENTRIES = 256;
  localparam int SINE_IDX_W   = $clog2(SINE_ENTRIES);
  localparam int SINE_W       = 16;
  localparam int SINE_ONE     = 32768;

  localparam int ANGLE_FRAC = 15;
  localparam int ANGLE_W    = 23;
  localparam int ANGLE_MID  = 90 * (1 << ANGLE_FRAC);
  localparam int ANGLE_MAX  = 180 * (1 << ANGLE_FRAC);
  localparam int ANGLE_SUM_W = ANGLE_W + 4;

  // pulse = 500 + floor(floor(angle * 100 / 2^15) / 9)
  localparam int SCALE_MUL    = 100;
  localparam int SC_PROD_W    = ANGLE_W + 7;
  localparam int SCALE_W      = SC_PROD_W - ANGLE_FRAC;
  localparam int RECIP_9      = 58255;
  localparam int RECIP_SHIFT  = 19;
  localparam int RECIP_PROD_W = SCALE_W + 16;
  localparam int PULSE_BASE   = 500;
  localparam int PULSE_MIN    = 500;
  localparam int PULSE_MAX    = 2500;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_BPM     = 3'd0,
    CFG_SPEED   = 3'd1,
    CFG_AMP     = 3'd2,
    CFG_ENABLE  = 3'd3,
    CFG_OFFSET0 = 3'd4,
    CFG_OFFSET1 = 3'd5,
    CFG_OFFSET2 = 3'd6
  } cfg_reg_e;

  typedef logic [SINE_W-1:0] sine_rom_t [SINE_ENTRIES+1];

  // taylor series in q30 up to x^13, rounded to q15
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t   rom;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    longint      sum;
    logic [63:0] q;
    for (int k = 0; k <= SINE_ENTRIES; k++) begin
      if (k == SINE_ENTRIES) begin
        rom[k] = SINE_W'(SINE_ONE);
      end else begin
        x    = (64'(k) * HALF_PI_Q30) / SINE_ENTRIES;
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        term = ((term * x2) >> 30) / 6;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 20;
        sum  = sum + longint'(term);
        term = ((term * x2) >> 30) / 42;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 72;
        sum  = sum + longint'(term);
        term = ((term * x2) >> 30) / 110;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 156;
        sum  = sum + longint'(term);
        if (sum < 0) sum = 0;
        q = (64'(sum) + 64'd16384) >> 15;
        if (q > 64'(SINE_ONE)) q = 64'(SINE_ONE);
        rom[k] = q[SINE_W-1:0];
      end
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

### sv/multi_servo_sine_oscillator.sv
// servo sine oscillator: bit-serial phase step, per-channel sine lookup and pulse mapping
//
// Each accepted tick yields one pulse width per channel, channel 0 first. With motion
// enabled it first advances every channel's phase by elapsed_us * bpm * speed turns
// over 60e6 * 256, speed being a q8 multiplier and both clamped to their ranges; the
// bit-serial shift-add multiply (one bit of elapsed_us a cycle) and the restoring
// divide that forms the phase step (one quotient bit a cycle) are followed by five steps
// per channel. With motion disabled every channel gets the base pulse width. The next
// request is taken only once the sequencer is back in idle. Results wait in an
// output register, so a stalled consumer only holds the sequencer when the next result
// is ready. Configuration is taken at any time on the cfg port, which is always ready.
module multi_servo_sine_oscillator #(
  parameter int NUM_CHANNELS = msso_pkg::NUM_CHANNELS_DEF,
  parameter int PHASE_BITS   = msso_pkg::PHASE_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [msso_pkg::ELAPSED_W-1:0]   elapsed_us_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [msso_pkg::CHANNEL_W-1:0]   channel_o,
  output logic [msso_pkg::PULSE_W-1:0]     pulse_width_us_o,
  output logic                             last_channel_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [msso_pkg::CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [msso_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import msso_pkg::*;

  localparam int CH_W      = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int CHX_W     = CH_W + 2;
  localparam int DIV_ITER  = PROD_W + PHASE_BITS;
  localparam int CNT_W     = $clog2(DIV_ITER + 1);
  localparam int OFF_SHIFT = PHASE_BITS - OFFSET_W;
  localparam int LUT_W     = SINE_IDX_W + 2;

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_MUL    = 8'b0000_0010,
    ST_DIV    = 8'b0000_0100,
    ST_PHASE  = 8'b0000_1000,
    ST_LOOKUP = 8'b0001_0000,
    ST_ANGLE  = 8'b0010_0000,
    ST_SCALE  = 8'b0100_0000,
    ST_EMIT   = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  logic [BPM_W-1:0]    bpm_q;
  logic [MUL_W-1:0]    mul_q;
  logic [AMP_W-1:0]    amp_q;
  logic                enable_q;
  logic [OFFSET_W-1:0] off_q [NUM_OFFSETS];

  logic [PHASE_BITS-1:0] phase_q [NUM_CHANNELS];
  logic [CNT_W-1:0]      cnt_q;
  logic [CH_W-1:0]       ch_q;
  logic                  out_valid_q;

  logic [ELAPSED_W-1:0]       us_q;
  logic [RATE_W-1:0]          rate_q;
  logic [PROD_W-1:0]          acc_q;
  logic [REM_W-1:0]           rem_q;
  logic [PHASE_BITS-1:0]      quo_q;
  logic [PHASE_BITS-1:0]      total_q;
  logic signed [SINE_W:0]     sine_q;
  logic [ANGLE_W-1:0]         angle_q;
  logic [SCALE_W-1:0]         scaled_q;
  logic [CHANNEL_W-1:0]       out_ch_q;
  logic [PULSE_W-1:0]         out_pulse_q;
  logic                       out_last_q;

  logic [BPM_W-1:0]           bpm_c;
  logic [MUL_W-1:0]           mul_c;
  logic [RATE_W-1:0]          rate_d;
  logic [PROD_W-1:0]          acc_mul;
  logic [REM_W:0]             div_t;
  logic                       div_ge;
  logic [REM_W:0]             div_r;
  logic [CHX_W-1:0]           ch_x;
  logic [OFFSET_W-1:0]        off_sel;
  logic [PHASE_BITS-1:0]      phase_new;
  logic [PHASE_BITS-1:0]      total_d;
  logic [LUT_W-1:0]           lut_i;
  logic [SINE_IDX_W:0]        rom_idx;
  logic [SINE_W-1:0]          rom_val;
  logic signed [SINE_W:0]     sine_d;
  logic signed [ANGLE_SUM_W-1:0] ang_sum;
  logic [ANGLE_W-1:0]         angle_d;
  logic [SC_PROD_W-1:0]       sc_full;
  logic [RECIP_PROD_W-1:0]    recip_full;
  logic [PULSE_W-1:0]         pulse_d;
  logic                       out_free;
  logic                       ch_last;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bpm_q    <= BPM_W'(BPM_RST);
      mul_q    <= MUL_W'(MUL_RST);
      amp_q    <= AMP_W'(AMP_RST);
      enable_q <= 1'b0;
      off_q[0] <= OFFSET_W'(OFF0_RST);
      off_q[1] <= OFFSET_W'(OFF1_RST);
      off_q[2] <= OFFSET_W'(OFF2_RST);
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_BPM:     bpm_q    <= cfg_data_i[BPM_W-1:0];
        CFG_SPEED:   mul_q    <= cfg_data_i[MUL_W-1:0];
        CFG_AMP:     amp_q    <= cfg_data_i[AMP_W-1:0];
        CFG_ENABLE:  enable_q <= cfg_data_i[0];
        CFG_OFFSET0: off_q[0] <= cfg_data_i[OFFSET_W-1:0];
        CFG_OFFSET1: off_q[1] <= cfg_data_i[OFFSET_W-1:0];
        CFG_OFFSET2: off_q[2] <= cfg_data_i[OFFSET_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  // rate clamp and product
  always_comb begin
    if (bpm_q < BPM_W'(BPM_MIN))      bpm_c = BPM_W'(BPM_MIN);
    else if (bpm_q > BPM_W'(BPM_MAX)) bpm_c = BPM_W'(BPM_MAX);
    else                              bpm_c = bpm_q;
    if (mul_q < MUL_W'(MUL_MIN))      mul_c = MUL_W'(MUL_MIN);
    else if (mul_q > MUL_W'(MUL_MAX)) mul_c = MUL_W'(MUL_MAX);
    else                              mul_c = mul_q;
  end

  assign rate_d = RATE_W'(bpm_c) * RATE_W'(mul_c);

  // shift-add multiply, msb first
  assign acc_mul = {acc_q[PROD_W-2:0], 1'b0}
                 + (us_q[ELAPSED_W-1] ? PROD_W'(rate_q) : {PROD_W{1'b0}});

  // restoring divide of elapsed product * 2^PHASE_BITS by one turn
  assign div_t  = {rem_q, acc_q[PROD_W-1]};
  assign div_ge = (div_t >= (REM_W + 1)'(TURN_DEN));
  assign div_r  = div_ge ? (div_t - (REM_W + 1)'(TURN_DEN)) : div_t;

  // phase update and offset
  assign ch_x = CHX_W'(ch_q);

  always_comb begin
    if (ch_x < CHX_W'(NUM_OFFSETS)) off_sel = off_q[ch_x[1:0]];
    else                             off_sel = '0;
  end

  assign phase_new = phase_q[ch_q] + quo_q;
  assign total_d   = phase_new + (PHASE_BITS'(off_sel) << OFF_SHIFT);

  // quarter-wave lookup
  assign lut_i   = total_q[PHASE_BITS-1 -: LUT_W];
  assign rom_idx = lut_i[SINE_IDX_W] ? ((SINE_IDX_W + 1)'(SINE_ENTRIES)
                                        - {1'b0, lut_i[SINE_IDX_W-1:0]})
                                     : {1'b0, lut_i[SINE_IDX_W-1:0]};
  assign rom_val = SINE_ROM[rom_idx];
  assign sine_d  = lut_i[LUT_W-1] ? -$signed({1'b0, rom_val}) : $signed({1'b0, rom_val});

  // angle in q15 degrees, clamped to 0..180
  assign ang_sum = ANGLE_SUM_W'($signed({1'b0, amp_q})) * ANGLE_SUM_W'(sine_q)
                 + ANGLE_SUM_W'(ANGLE_MID);

  always_comb begin
    if (ang_sum < 0)                             angle_d = '0;
    else if (ang_sum > ANGLE_SUM_W'(ANGLE_MAX))  angle_d = ANGLE_W'(ANGLE_MAX);
    else                                         angle_d = ang_sum[ANGLE_W-1:0];
  end

  assign sc_full    = SC_PROD_W'(angle_q) * SC_PROD_W'(SCALE_MUL);
  assign recip_full = RECIP_PROD_W'(scaled_q) * RECIP_PROD_W'(RECIP_9);
  assign pulse_d    = recip_full[RECIP_SHIFT +: PULSE_W] + PULSE_W'(PULSE_BASE);

  assign out_free = !out_valid_q || out_ready_i;
  assign ch_last  = (ch_q == CH_W'(NUM_CHANNELS - 1));

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = enable_q ? ST_MUL : ST_EMIT;
      ST_MUL:    if (cnt_q == CNT_W'(ELAPSED_W - 1)) state_d = ST_DIV;
      ST_DIV:    if (cnt_q == CNT_W'(DIV_ITER - 1)) state_d = ST_PHASE;
      ST_PHASE:  state_d = ST_LOOKUP;
      ST_LOOKUP: state_d = ST_ANGLE;
      ST_ANGLE:  state_d = ST_SCALE;
      ST_SCALE:  state_d = ST_EMIT;
      ST_EMIT: begin
        if (out_free) begin
          if (ch_last)       state_d = ST_IDLE;
          else if (enable_q) state_d = ST_PHASE;
          else               state_d = ST_EMIT;
        end
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  // control state and channel phases
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      ch_q        <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NUM_CHANNELS; i++) phase_q[i] <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        ST_IDLE: begin
          cnt_q <= '0;
          ch_q  <= '0;
        end
        ST_MUL: begin
          if (cnt_q == CNT_W'(ELAPSED_W - 1)) cnt_q <= '0;
          else                                cnt_q <= cnt_q + CNT_W'(1);
        end
        ST_DIV:   cnt_q <= cnt_q + CNT_W'(1);
        ST_PHASE: phase_q[ch_q] <= phase_new;
        ST_EMIT: begin
          if (out_free && !ch_last) ch_q <= ch_q + CH_W'(1);
        end
        default: ;
      endcase
      if (state_q == ST_EMIT && out_free) out_valid_q <= 1'b1;
      else if (out_ready_i)               out_valid_q <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          us_q     <= elapsed_us_i;
          rate_q   <= rate_d;
          acc_q    <= '0;
          rem_q    <= '0;
          scaled_q <= '0;
        end
      end
      ST_MUL: begin
        acc_q <= acc_mul;
        us_q  <= {us_q[ELAPSED_W-2:0], 1'b0};
      end
      ST_DIV: begin
        acc_q <= {acc_q[PROD_W-2:0], 1'b0};
        rem_q <= div_r[REM_W-1:0];
        quo_q <= {quo_q[PHASE_BITS-2:0], div_ge};
      end
      ST_PHASE:  total_q  <= total_d;
      ST_LOOKUP: sine_q   <= sine_d;
      ST_ANGLE:  angle_q  <= angle_d;
      ST_SCALE:  scaled_q <= sc_full[ANGLE_FRAC +: SCALE_W];
      ST_EMIT: begin
        if (out_free) begin
          out_ch_q    <= ch_x[CHANNEL_W-1:0];
          out_pulse_q <= pulse_d;
          out_last_q  <= ch_last;
        end
      end
      default: ;
    endcase
  end

  assign in_ready_o       = (state_q == ST_IDLE);
  assign out_valid_o      = out_valid_q;
  assign channel_o        = out_ch_q;
  assign pulse_width_us_o = out_pulse_q;
  assign last_channel_o   = out_last_q;

endmodule

### sv/msso_checker.sv
// port-level checks for the servo sine oscillator and their bind
module msso_checker #(
  parameter int NUM_CHANNELS = msso_pkg::NUM_CHANNELS_DEF
) (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_ready_o,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input logic [msso_pkg::CHANNEL_W-1:0] channel_o,
  input logic [msso_pkg::PULSE_W-1:0]   pulse_width_us_o,
  input logic                           last_channel_o
);
  import msso_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(channel_o)
      && $stable(pulse_width_us_o) && $stable(last_channel_o))
    else $error("result changed while stalled");

  a_pulse_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pulse_width_us_o >= PULSE_W'(PULSE_MIN)
      && pulse_width_us_o <= PULSE_W'(PULSE_MAX))
    else $error("pulse width out of range");

  a_last_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_channel_o |-> channel_o == CHANNEL_W'(NUM_CHANNELS - 1))
    else $error("last flag on wrong channel");

  a_tick_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_channel_o |-> !in_ready_o)
    else $error("new request taken before tick finished");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready after request");

endmodule

bind multi_servo_sine_oscillator msso_checker #(.NUM_CHANNELS(NUM_CHANNELS)) u_msso_checker (.*);

### test/msso_pulse_checker.sv
`timescale 1ns / 100ps
// watches the tick, result and register channels, predicts every pulse width and compares
module msso_pulse_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  input  logic                             in_ready_i,
  input  logic [msso_pkg::ELAPSED_W-1:0]   elapsed_us_i,
  input  logic                             out_valid_i,
  input  logic                             out_ready_i,
  input  logic [msso_pkg::CHANNEL_W-1:0]   channel_i,
  input  logic [msso_pkg::PULSE_W-1:0]     pulse_width_us_i,
  input  logic                             last_channel_i,
  input  logic                             cfg_valid_i,
  input  logic                             cfg_ready_i,
  input  logic [msso_pkg::CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [msso_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output int                               mismatches_o,
  output int                               pending_o
);
  import msso_pkg::*;

  localparam int CHANNELS = NUM_CHANNELS_DEF;
  localparam int PHASE_W  = PHASE_BITS_DEF;

  typedef struct packed {
    logic [CHANNEL_W-1:0] channel;
    logic [PULSE_W-1:0]   pulse;
    logic                 last;
  } servo_pulse_t;

  servo_pulse_t         expected_pulses [$];
  logic [SINE_W-1:0]    quarter_wave [SINE_ENTRIES+1];
  logic [BPM_W-1:0]     bpm_q;
  logic [MUL_W-1:0]     speed_q;
  logic [AMP_W-1:0]     amp_q;
  logic                 enable_q;
  logic [OFFSET_W-1:0]  offset_q [NUM_OFFSETS];
  logic [PHASE_W-1:0]   phase_q [CHANNELS];

  function automatic logic [SINE_W-1:0] taylor_quarter_sine(int k);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    longint      acc;
    logic [63:0] rounded;
    if (k >= SINE_ENTRIES) return SINE_W'(SINE_ONE);
    x    = (64'(k) * HALF_PI_Q30) / SINE_ENTRIES;
    x2   = (x * x) >> 30;
    term = x;
    acc  = longint'(x);
    for (int n = 1; n <= 6; n++) begin
      term = ((term * x2) >> 30) / 64'(2 * n * (2 * n + 1));
      if (n % 2 == 1) acc = acc - longint'(term);
      else acc = acc + longint'(term);
    end
    if (acc < 0) acc = 0;
    rounded = (64'(acc) + 64'd16384) >> 15;
    if (rounded > 64'(SINE_ONE)) rounded = 64'(SINE_ONE);
    return rounded[SINE_W-1:0];
  endfunction

  // exact fraction of a turn, truncated
  function automatic logic [PHASE_W-1:0] phase_increment(logic [ELAPSED_W-1:0] us,
                                                         logic [BPM_W-1:0] bpm,
                                                         logic [MUL_W-1:0] mul);
    logic [63:0]  rate_bpm;
    logic [63:0]  rate_mul;
    logic [63:0]  leftover;
    logic [127:0] frac;
    rate_bpm = (bpm < BPM_MIN) ? BPM_MIN : (bpm > BPM_MAX) ? BPM_MAX : bpm;
    rate_mul = (mul < MUL_MIN) ? MUL_MIN : (mul > MUL_MAX) ? MUL_MAX : mul;
    leftover = (64'(us) * rate_bpm * rate_mul) % TURN_DEN;
    frac     = (128'(leftover) << PHASE_W) / 128'(TURN_DEN);
    return frac[PHASE_W-1:0];
  endfunction

  function automatic int wave_sample(logic [PHASE_W-1:0] total);
    logic [1:0]            quadrant;
    logic [SINE_IDX_W-1:0] k;
    quadrant = total[PHASE_W-1 -: 2];
    k        = total[PHASE_W-3 -: SINE_IDX_W];
    case (quadrant)
      2'd0:    return int'(quarter_wave[k]);
      2'd1:    return int'(quarter_wave[SINE_ENTRIES - int'(k)]);
      2'd2:    return -int'(quarter_wave[k]);
      default: return -int'(quarter_wave[SINE_ENTRIES - int'(k)]);
    endcase
  endfunction

  function automatic logic [PULSE_W-1:0] angle_to_pulse(int sine, logic [AMP_W-1:0] amp);
    longint angle;
    longint width;
    angle = longint'(ANGLE_MID) + longint'(amp) * longint'(sine);
    if (angle < 0) angle = 0;
    if (angle > ANGLE_MAX) angle = ANGLE_MAX;
    width = PULSE_BASE + (longint'(PULSE_MAX - PULSE_MIN) * angle) / longint'(ANGLE_MAX);
    return width[PULSE_W-1:0];
  endfunction

  initial begin
    for (int k = 0; k <= SINE_ENTRIES; k++) quarter_wave[k] = taylor_quarter_sine(k);
  end

  always @(posedge clk_i or negedge rst_ni) begin : track
    logic [PHASE_W-1:0] step;
    logic [PHASE_W-1:0] total;
    servo_pulse_t       seen;
    servo_pulse_t       want;
    if (!rst_ni) begin
      bpm_q       = BPM_W'(BPM_RST);
      speed_q     = MUL_W'(MUL_RST);
      amp_q       = AMP_W'(AMP_RST);
      enable_q    = 1'b0;
      offset_q[0] = OFFSET_W'(OFF0_RST);
      offset_q[1] = OFFSET_W'(OFF1_RST);
      offset_q[2] = OFFSET_W'(OFF2_RST);
      for (int c = 0; c < CHANNELS; c++) phase_q[c] = '0;
      expected_pulses.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_BPM:     bpm_q       = cfg_data_i[BPM_W-1:0];
          CFG_SPEED:   speed_q     = cfg_data_i[MUL_W-1:0];
          CFG_AMP:     amp_q       = cfg_data_i[AMP_W-1:0];
          CFG_ENABLE:  enable_q    = cfg_data_i[0];
          CFG_OFFSET0: offset_q[0] = cfg_data_i[OFFSET_W-1:0];
          CFG_OFFSET1: offset_q[1] = cfg_data_i[OFFSET_W-1:0];
          CFG_OFFSET2: offset_q[2] = cfg_data_i[OFFSET_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        step = phase_increment(elapsed_us_i, bpm_q, speed_q);
        for (int c = 0; c < CHANNELS; c++) begin
          want.channel = CHANNEL_W'(c);
          want.pulse   = PULSE_W'(PULSE_MIN);
          want.last    = (c == CHANNELS - 1);
          if (enable_q) begin
            phase_q[c] = phase_q[c] + step;
            total      = phase_q[c] + (PHASE_W'(offset_q[c]) << (PHASE_W - OFFSET_W));
            want.pulse = angle_to_pulse(wave_sample(total), amp_q);
          end
          expected_pulses.push_back(want);
        end
      end
      if (out_valid_i && out_ready_i) begin
        seen = {channel_i, pulse_width_us_i, last_channel_i};
        if (expected_pulses.size() == 0) begin
          $display("%0t: unexpected result, expected none, got channel %0d pulse %0d last %0d",
                   $time, seen.channel, seen.pulse, seen.last);
          mismatches_o++;
        end else begin
          want = expected_pulses.pop_front();
          if (seen.channel !== want.channel) begin
            $display("%0t: channel expected %0d got %0d", $time, want.channel, seen.channel);
            mismatches_o++;
          end
          if (seen.pulse !== want.pulse) begin
            $display("%0t: pulse width on channel %0d expected %0d got %0d",
                     $time, want.channel, want.pulse, seen.pulse);
            mismatches_o++;
          end
          if (seen.last !== want.last) begin
            $display("%0t: last flag on channel %0d expected %0d got %0d",
                     $time, want.channel, want.last, seen.last);
            mismatches_o++;
          end
        end
      end
    end
    pending_o = expected_pulses.size();
  end

endmodule

### test/tb_multi_servo_sine_oscillator.sv
`timescale 1ns / 100ps
// testbench top: clock, reset, tick and register stimulus, result sink and verdict
module tb_multi_servo_sine_oscillator;
  import msso_pkg::*;

  localparam int TICK_TARGET     = 270;
  localparam int LONG_HOLD       = 700;
  localparam int STALL_LIMIT     = 5000;
  localparam int DRAIN_CYCLES    = 120;
  localparam int AMP_FULL_SWING  = 180;
  localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 3'd7;

  logic                   clk;
  logic                   rst_n;
  logic                   tick_valid;
  logic                   tick_ready;
  logic [ELAPSED_W-1:0]   elapsed_us;
  logic                   pulse_valid;
  logic                   pulse_ready;
  logic [CHANNEL_W-1:0]   channel;
  logic [PULSE_W-1:0]     pulse_width_us;
  logic                   last_channel;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  int mismatches;
  int pending;
  int ticks_sent;
  int hold_offs_asked;
  int hold_offs_done;

  multi_servo_sine_oscillator DUT (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (tick_valid),
    .in_ready_o       (tick_ready),
    .elapsed_us_i     (elapsed_us),
    .out_valid_o      (pulse_valid),
    .out_ready_i      (pulse_ready),
    .channel_o        (channel),
    .pulse_width_us_o (pulse_width_us),
    .last_channel_o   (last_channel),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data)
  );

  msso_pulse_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (tick_valid),
    .in_ready_i       (tick_ready),
    .elapsed_us_i     (elapsed_us),
    .out_valid_i      (pulse_valid),
    .out_ready_i      (pulse_ready),
    .channel_i        (channel),
    .pulse_width_us_i (pulse_width_us),
    .last_channel_i   (last_channel),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .mismatches_o     (mismatches),
    .pending_o        (pending)
  );

  always #2 clk = ~clk;

  function automatic int gap_cycles();
    case ($urandom_range(0, 19))
      0, 1, 2, 3, 4, 5, 6, 7, 8, 9: return 0;
      18, 19:                       return int'($urandom_range(15, 60));
      default:                      return int'($urandom_range(1, 3));
    endcase
  endfunction

  function automatic logic [ELAPSED_W-1:0] random_elapsed();
    case ($urandom_range(0, 9))
      0:       return '1;
      1:       return '0;
      2, 3, 4: return ELAPSED_W'($urandom_range(0, (1 << ELAPSED_W) - 1));
      default: return ELAPSED_W'($urandom_range(500, 30000));
    endcase
  endfunction

  function automatic int pick_extreme(int lo, int hi, int width);
    case ($urandom_range(0, 5))
      0:       return 0;
      1:       return (1 << width) - 1;
      2:       return lo;
      3:       return hi;
      default: return int'($urandom_range(0, (1 << width) - 1));
    endcase
  endfunction

  task automatic send_tick(input logic [ELAPSED_W-1:0] us);
    int gap;
    gap = gap_cycles();
    @(negedge clk);
    if (gap > 0) begin
      tick_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    tick_valid <= 1'b1;
    elapsed_us <= us;
    do @(posedge clk); while (!tick_ready);
    ticks_sent++;
  endtask

  // unused data bits above the register width are random
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int value, input int width);
    int mask;
    mask = (1 << width) - 1;
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'((int'($urandom) & ~mask) | (value & mask));
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    tick_valid <= 1'b0;
    while (pending != 0 || !tick_ready) @(negedge clk);
  endtask

  task automatic load_regs(input int bpm, input int mul, input int amp, input int en,
                           input int off0, input int off1, input int off2);
    wait_idle();
    write_reg(CFG_BPM, bpm, BPM_W);
    write_reg(CFG_SPEED, mul, MUL_W);
    write_reg(CFG_AMP, amp, AMP_W);
    write_reg(CFG_ENABLE, en, 1);
    write_reg(CFG_OFFSET0, off0, OFFSET_W);
    write_reg(CFG_OFFSET1, off1, OFFSET_W);
    write_reg(CFG_OFFSET2, off2, OFFSET_W);
  endtask

  initial begin : stimulus
    int round;
    clk             = 1'b0;
    rst_n           = 1'b0;
    tick_valid      = 1'b0;
    elapsed_us      = '0;
    cfg_valid       = 1'b0;
    cfg_index       = CFG_BPM;
    cfg_data        = '0;
    ticks_sent      = 0;
    hold_offs_asked = 0;
    hold_offs_done  = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // disabled after reset
    send_tick('0);
    send_tick('1);

    load_regs(BPM_RST, MUL_RST, AMP_RST, 1, OFF0_RST, OFF1_RST, OFF2_RST);
    send_tick('0);
    send_tick(ELAPSED_W'(1));
    send_tick(ELAPSED_W'(1000));
    send_tick('1);
    send_tick(ELAPSED_W'(20'h80000));
    send_tick(ELAPSED_W'(20'h55555));
    send_tick(ELAPSED_W'(20'hAAAAA));

    // rate below range, amplitude past the clamp
    load_regs(0, 0, 255, 1, 0, 32768, 65535);
    send_tick('1);
    send_tick(ELAPSED_W'(12345));

    // rate above range
    load_regs(255, 2047, AMP_FULL_SWING, 1, 65535, 65535, 65535);
    send_tick('1);
    send_tick(ELAPSED_W'(777));
    send_tick(ELAPSED_W'(40000));

    load_regs(BPM_MIN, MUL_MAX, 0, 1, 0, 0, 0);
    write_reg(CFG_UNUSED, 16'hFFFF, CFG_DATA_W);
    send_tick(ELAPSED_W'(5000));
    send_tick('1);

    load_regs(BPM_MAX, MUL_MIN, AMP_RST, 1, 16384, 32768, 49152);
    send_tick(ELAPSED_W'(999));
    send_tick(ELAPSED_W'(20'h3FFFF));
    send_tick('1);

    // disabled again, phases held
    wait_idle();
    write_reg(CFG_ENABLE, 0, 1);
    send_tick('1);
    send_tick(ELAPSED_W'(2500));

    round = 0;
    while (ticks_sent < TICK_TARGET) begin
      load_regs(pick_extreme(BPM_MIN, BPM_MAX, BPM_W),
                pick_extreme(MUL_MIN, MUL_MAX, MUL_W),
                pick_extreme(0, AMP_FULL_SWING, AMP_W),
                ($urandom_range(0, 4) != 0),
                pick_extreme(0, 1 << (OFFSET_W - 1), OFFSET_W),
                pick_extreme(0, 1 << (OFFSET_W - 1), OFFSET_W),
                pick_extreme(0, 1 << (OFFSET_W - 1), OFFSET_W));
      if ($urandom_range(0, 3) == 0) write_reg(CFG_UNUSED, int'($urandom), CFG_DATA_W);
      if (round == 1) begin
        hold_offs_asked++;
        write_reg(CFG_ENABLE, 1, 1);
        repeat (30) send_tick(random_elapsed());
      end else begin
        repeat ($urandom_range(10, 40)) send_tick(random_elapsed());
      end
      round++;
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin : result_sink
    int level;
    int span;
    pulse_ready = 1'b0;
    wait (rst_n);
    forever begin
      if (hold_offs_done < hold_offs_asked) begin
        hold_offs_done++;
        level = 0;
        span  = LONG_HOLD;
      end else begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: begin
            level = 1;
            span  = int'($urandom_range(1, 40));
          end
          9: begin
            level = 0;
            span  = int'($urandom_range(20, 80));
          end
          default: begin
            level = 0;
            span  = int'($urandom_range(1, 3));
          end
        endcase
      end
      repeat (span) begin
        @(negedge clk);
        pulse_ready <= level[0];
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((tick_valid && tick_ready) || (pulse_valid && pulse_ready) ||
          (cfg_valid && cfg_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
